>>> rtl/core/prsd_pkg.sv
package prsd_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef enum logic [3:0] {
		K_IDLE    = 4'd0,
		K_BUSYON  = 4'd1,
		K_BUSYOFF = 4'd2,
		K_HEADER  = 4'd3,
		K_TRAILER = 4'd4,
		K_EMPTY   = 4'd5,
		K_REGION  = 4'd6,
		K_SHORT   = 4'd7,
		K_LONG    = 4'd8,
		K_UNKNOWN = 4'd9
	} word_kind_t;

	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_UNFINISHED   = 4'd1;
	localparam logic [3:0] ST_NOT_STARTED  = 4'd2;
	localparam logic [3:0] ST_TRL_NO_HDR   = 4'd3;
	localparam logic [3:0] ST_TRL_FINISHED = 4'd4;
	localparam logic [3:0] ST_REGION_EARLY = 4'd5;
	localparam logic [3:0] ST_DATA_EARLY   = 4'd6;
	localparam logic [3:0] ST_UNKNOWN      = 4'd7;
	localparam logic [3:0] ST_TRUNCATED    = 4'd8;

	localparam logic [1:0] WARN_NONE   = 2'd0;
	localparam logic [1:0] WARN_REPEAT = 2'd1;
	localparam logic [1:0] WARN_LOWER  = 2'd2;

	localparam logic [4:0] CHIP_NONE = 5'h1f;

	// one queued job: the hits of a data word and/or an event status
	typedef struct packed {
		logic       has_hits;
		logic [7:0] hit_mask;
		logic [4:0] region;
		logic [3:0] dcol;
		logic [9:0] addr;
		logic [1:0] warn;
		logic       has_status;
		logic [3:0] status;
		logic [7:0] skip;
		logic [4:0] chip;
		logic [7:0] bunch;
		logic [3:0] flags;
	} prsd_job_t;

	function automatic word_kind_t classify(input logic [7:0] b);
		word_kind_t k;
		if (b == 8'hff) k = K_IDLE;
		else if (b == 8'hf1) k = K_BUSYON;
		else if (b == 8'hf0) k = K_BUSYOFF;
		else if ((b & 8'hf0) == 8'ha0) k = K_HEADER;
		else if ((b & 8'hf0) == 8'hb0) k = K_TRAILER;
		else if ((b & 8'hf0) == 8'he0) k = K_EMPTY;
		else if ((b & 8'he0) == 8'hc0) k = K_REGION;
		else if ((b & 8'hc0) == 8'h40) k = K_SHORT;
		else if ((b & 8'hc0) == 8'h00) k = K_LONG;
		else k = K_UNKNOWN;
		return k;
	endfunction

	function automatic logic [1:0] word_length(input word_kind_t k);
		logic [1:0] n;
		case (k)
			K_LONG: n = 2'd3;
			K_SHORT, K_HEADER, K_EMPTY: n = 2'd2;
			default: n = 2'd1;
		endcase
		return n;
	endfunction

endpackage

>>> rtl/core/prsd_front.sv
module prsd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         data_byte,
	input  logic               end_of_event,
	output logic               push,
	output prsd_pkg::prsd_job_t job
);
	import prsd_pkg::*;

	logic [7:0]  byte0_q, byte1_q;
	logic [1:0]  pos_q;
	word_kind_t  kind_q;
	logic        started_q, finished_q, fresh_q, keyv_q, regv_q;
	logic [4:0]  chip_q, region_q;
	logic [7:0]  bunch_q, skip_q;
	logic [3:0]  flags_q, err_q;
	logic [19:0] key_q;

	logic [1:0]  pos_n;
	word_kind_t  kind_n;
	logic        started_n, finished_n, fresh_n, keyv_n, regv_n;
	logic [4:0]  chip_n, region_n;
	logic [7:0]  bunch_n, skip_n;
	logic [3:0]  flags_n, err_n;
	logic [19:0] key_n;
	logic        push_n;
	prsd_job_t   job_n;

	always_comb begin
		logic       dec;
		word_kind_t dk;
		logic [7:0] w0, w1, w2;
		logic [2:0] hi;
		logic [3:0] st;
		pos_n = pos_q; kind_n = kind_q; started_n = started_q; finished_n = finished_q;
		fresh_n = fresh_q; keyv_n = keyv_q; regv_n = regv_q; chip_n = chip_q;
		region_n = region_q; bunch_n = bunch_q; skip_n = skip_q; flags_n = flags_q;
		err_n = err_q; key_n = key_q;
		dec = 1'b0; dk = kind_q; w0 = byte0_q; w1 = byte1_q; w2 = data_byte;
		hi = 3'd0; st = ST_OK;
		job_n = '0;
		if (err_q == ST_OK) begin
			case (pos_q)
				2'd0: begin
					dk = classify(data_byte);
					kind_n = dk;
					w0 = data_byte;
					if (word_length(dk) == 2'd1) dec = 1'b1;
					else pos_n = 2'd1;
				end
				2'd1: begin
					w1 = data_byte;
					if (word_length(kind_q) == 2'd2) begin
						pos_n = 2'd0;
						dec = 1'b1;
					end else begin
						pos_n = 2'd2;
					end
				end
				default: begin
					pos_n = 2'd0;
					dec = 1'b1;
				end
			endcase
		end
		if (dec) begin
			case (dk)
				K_EMPTY: begin
					started_n = 1'b1; finished_n = 1'b1;
					chip_n = {1'b0, w0[3:0]}; bunch_n = w1;
				end
				K_HEADER: begin
					started_n = 1'b1; finished_n = 1'b0;
					chip_n = {1'b0, w0[3:0]}; bunch_n = w1; fresh_n = 1'b1;
				end
				K_TRAILER: begin
					if (!started_q) err_n = ST_TRL_NO_HDR;
					else if (finished_q) err_n = ST_TRL_FINISHED;
					else begin
						flags_n = w0[3:0]; finished_n = 1'b1; chip_n = CHIP_NONE;
					end
				end
				K_REGION: begin
					if (!started_q) err_n = ST_REGION_EARLY;
					else begin
						regv_n = 1'b1; region_n = w0[4:0];
					end
				end
				K_SHORT, K_LONG: begin
					if (!started_q) err_n = ST_DATA_EARLY;
					else if (!regv_q) begin
						if (skip_q != 8'hff) skip_n = skip_q + 8'd1;
					end else begin
						job_n.has_hits = 1'b1;
						job_n.region = region_q;
						job_n.dcol = w0[5:2];
						job_n.addr = {w0[1:0], w1};
						job_n.hit_mask = (dk == K_LONG) ? {w2[6:0], 1'b1} : 8'h01;
						if (keyv_q && !fresh_q && key_q[19:11] == {region_q, w0[5:2]}) begin
							if (key_q[10:0] == {1'b0, w0[1:0], w1}) job_n.warn = WARN_REPEAT;
							else if ({1'b0, w0[1:0], w1} < key_q[10:0]) job_n.warn = WARN_LOWER;
						end
						// the last hit of the word becomes the new reference
						for (int i = 0; i < 8; i++) begin
							if (job_n.hit_mask[i]) hi = 3'(i);
						end
						key_n = {region_q, w0[5:2], 11'({w0[1:0], w1}) + 11'(hi)};
						keyv_n = 1'b1;
						fresh_n = 1'b0;
					end
				end
				K_UNKNOWN: err_n = ST_UNKNOWN;
				default: ;
			endcase
			if (err_n != ST_OK) pos_n = 2'd0;
		end
		job_n.chip = chip_n; job_n.bunch = bunch_n; job_n.flags = flags_n;
		if (end_of_event) begin
			if (err_n == ST_OK && pos_n != 2'd0) err_n = ST_TRUNCATED;
			if (err_n != ST_OK) st = err_n;
			else if (started_n && finished_n) st = ST_OK;
			else if (started_n) st = ST_UNFINISHED;
			else st = ST_NOT_STARTED;
			job_n.has_status = 1'b1;
			job_n.status = st;
			job_n.skip = skip_n;
			pos_n = 2'd0; kind_n = K_IDLE; started_n = 1'b0; finished_n = 1'b0;
			chip_n = CHIP_NONE; regv_n = 1'b0; region_n = 5'd0; bunch_n = 8'd0;
			flags_n = 4'd0; err_n = ST_OK; skip_n = 8'd0;
		end
		push_n = job_n.has_hits | job_n.has_status;
	end

	assign push = accept & push_n;
	assign job = job_n;

	always_ff @(posedge clk) begin
		if (accept && err_q == ST_OK) begin
			if (pos_q == 2'd0) byte0_q <= data_byte;
			if (pos_q == 2'd1) byte1_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 2'd0; kind_q <= K_IDLE; started_q <= 1'b0; finished_q <= 1'b0;
			fresh_q <= 1'b0; keyv_q <= 1'b0; regv_q <= 1'b0; chip_q <= CHIP_NONE;
			region_q <= 5'd0; bunch_q <= 8'd0; skip_q <= 8'd0; flags_q <= 4'd0;
			err_q <= ST_OK; key_q <= 20'd0;
		end else if (accept) begin
			pos_q <= pos_n; kind_q <= kind_n; started_q <= started_n;
			finished_q <= finished_n; fresh_q <= fresh_n; keyv_q <= keyv_n;
			regv_q <= regv_n; chip_q <= chip_n; region_q <= region_n;
			bunch_q <= bunch_n; skip_q <= skip_n; flags_q <= flags_n;
			err_q <= err_n; key_q <= key_n;
		end
	end

endmodule

>>> rtl/core/prsd_queue.sv
module prsd_queue #(
	parameter int DEPTH = prsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  prsd_pkg::prsd_job_t push_job,
	input  logic               pop,
	output prsd_pkg::prsd_job_t head_job,
	output logic               empty,
	output logic               full
);
	import prsd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	prsd_job_t      mem_q [DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CW-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == CW'(DEPTH));
	assign head_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> rtl/core/prsd_back.sv
module prsd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_avail,
	input  prsd_pkg::prsd_job_t head_job,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [55:0]        m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);
	import prsd_pkg::*;

	prsd_job_t  cur_q;
	logic       cur_valid_q, out_valid_q;
	logic [7:0] mask_q;
	logic       stat_q;
	logic [55:0] data_q;
	logic       user_q, last_q;

	logic       load_ok;
	logic [2:0] idx;
	logic [7:0] mask_n;
	logic [55:0] data_n;
	logic       user_n, last_n;

	assign load_ok = !out_valid_q || m_tready;
	assign pop = !cur_valid_q && job_avail;

	always_comb begin
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (mask_q[i]) idx = 3'(i);
		end
		mask_n = mask_q & ~(8'd1 << idx);
		data_n = '0;
		data_n[4:0] = cur_q.chip;
		data_n[32:25] = cur_q.bunch;
		data_n[36:33] = cur_q.flags;
		if (mask_q != 8'd0) begin
			data_n[9:5] = cur_q.region;
			data_n[13:10] = cur_q.dcol;
			data_n[24:14] = 11'(cur_q.addr) + 11'(idx);
			data_n[42:41] = cur_q.warn;
			user_n = 1'b0;
			last_n = (mask_n == 8'd0) && !stat_q;
		end else begin
			data_n[40:37] = cur_q.status;
			data_n[50:43] = cur_q.skip;
			user_n = 1'b1;
			last_n = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head_job;
		if (cur_valid_q && load_ok) begin
			data_q <= data_n;
			user_q <= user_n;
			last_q <= last_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0; out_valid_q <= 1'b0; mask_q <= 8'd0; stat_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				mask_q <= head_job.has_hits ? head_job.hit_mask : 8'd0;
				stat_q <= head_job.has_status;
			end else if (cur_valid_q && load_ok) begin
				if (mask_q != 8'd0) mask_q <= mask_n;
				else stat_q <= 1'b0;
				if (last_n) cur_valid_q <= 1'b0;
			end
			if (cur_valid_q && load_ok) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = data_q;
	assign m_tuser = user_q;
	assign m_tlast = last_q;

endmodule

>>> rtl/core/pixel_readout_stream_decoder.sv
// channel  dir  tdata                   tuser        tlast
// s_       in   data_byte[7:0]          -            end_of_event
// m_       out  result fields, 56 bits  result_kind  last_of_run
//
// one byte is taken each cycle while the job queue has room
// a data word leaves as one result per cycle while m_tready stays high: up to eight
// for a long word, once its job has been loaded into the output unit
// an end mark adds one status word after the hits of its byte
// asynchronous reset, no clearing pass; stalls on m_ fill the queue, then hold s_
module pixel_readout_stream_decoder #(
	parameter int QUEUE_DEPTH = prsd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// hit_chip[4:0] region_index[9:5] col_pair[13:10] pixel_address[24:14]
	// hit_bunch[32:25] trailer_bits[36:33] status[40:37] warn_code[42:41]
	// skipped_words[50:43], zero fill above
	output logic [55:0] m_tdata,
	output logic        m_tuser,  // result_kind
	output logic        m_tlast
);
	import prsd_pkg::*;

	logic      accept, push, pop, empty, full;
	prsd_job_t push_job, head_job;

	assign s_tready = !full;
	assign accept = s_tvalid && s_tready;

	prsd_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .data_byte(s_tdata),
		.end_of_event(s_tlast), .push(push), .job(push_job)
	);

	prsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job), .pop(pop),
		.head_job(head_job), .empty(empty), .full(full)
	);

	prsd_back u_back (
		.clk(clk), .arst_n(arst_n), .job_avail(!empty), .head_job(head_job), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

endmodule

>>> rtl/core/prsd_checker.sv
module prsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled word stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word withdrawn under stall");

	// status closes the run of its byte
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("status word not last");

	a_hit_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[40:37] == 4'd0 && m_tdata[50:43] == 8'd0)
		else $error("hit word carries status or skip count");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[24:5] == 20'd0 && m_tdata[42:41] == 2'd0)
		else $error("status word carries hit fields");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[24:14] <= 11'd1030 && m_tdata[55:51] == 5'd0)
		else $error("address out of range or fill bits set");

endmodule

bind pixel_readout_stream_decoder prsd_checker u_prsd_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);

>>> test/pixel_readout_stream_decoder_test.sv
`timescale 1ns / 100ps

module pixel_readout_stream_decoder_test;
	import prsd_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [4:0] chip;
		logic [4:0] region;
		logic [3:0] dcol;
		logic [10:0] addr;
		logic [7:0] bunch;
		logic [3:0] flags;
		logic [3:0] status;
		logic [1:0] warn;
		logic [7:0] skip;
		logic       last;
	} readout_result_t;

	// software image of the decoder, fed one byte at a time
	class readout_scoreboard;
		logic [7:0] word0, word1;
		logic [1:0] wpos;
		word_kind_t wkind;
		bit started, finished, fresh, prev_valid;
		logic [4:0] chip;
		logic [5:0] region;
		logic [7:0] bunch, skip;
		logic [3:0] flags, err;
		logic [19:0] prev_key;
		readout_result_t pending[$];
		int errors;
		int hits_seen, status_seen;

		function void clear_event();
			wpos = 0; wkind = K_IDLE; started = 0; finished = 0;
			chip = CHIP_NONE; region = 6'h3f; bunch = 0; flags = 0; err = 0; skip = 0;
		endfunction

		function new();
			word0 = 0; word1 = 0; fresh = 0; prev_key = 0; prev_valid = 0;
			errors = 0; hits_seen = 0; status_seen = 0;
			clear_event();
		endfunction

		function void flag_error(logic [3:0] code);
			if (err == ST_OK) err = code;
		endfunction

		function void push(logic kind, logic [4:0] rg, logic [3:0] dc, logic [10:0] a,
				logic [3:0] st, logic [1:0] w, logic [7:0] sk);
			readout_result_t r;
			r.kind = kind; r.chip = chip; r.region = rg; r.dcol = dc; r.addr = a;
			r.bunch = bunch; r.flags = flags; r.status = st; r.warn = w; r.skip = sk;
			r.last = 0;
			pending = {pending, r};
		endfunction

		function void data_hits(logic [7:0] b0, logic [7:0] b1, logic [7:0] map, bit is_long);
			logic [4:0] rg;
			logic [3:0] dc;
			logic [10:0] a;
			logic [1:0] w;
			w = WARN_NONE;
			if (!started) begin
				flag_error(ST_DATA_EARLY);
				return;
			end
			if (region == 6'h3f) begin
				if (skip != 8'hff) skip++;
				return;
			end
			rg = region[4:0];
			dc = b0[5:2];
			a = {1'b0, b0[1:0], b1};
			if (prev_valid && !fresh && prev_key[19:11] == {rg, dc}) begin
				if (a == prev_key[10:0]) w = WARN_REPEAT;
				else if (a < prev_key[10:0]) w = WARN_LOWER;
			end
			for (int i = 0; i < 8; i++) begin
				if (i > 0 && (!is_long || !map[i-1])) continue;
				push(1'b0, rg, dc, a + 11'(i), ST_OK, w, 8'd0);
				prev_key = {rg, dc, a + 11'(i)};
				prev_valid = 1;
			end
			fresh = 0;
		endfunction

		function void decode(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
			case (wkind)
				K_EMPTY: begin
					started = 1; chip = {1'b0, b0[3:0]}; bunch = b1; finished = 1;
				end
				K_HEADER: begin
					started = 1; finished = 0; chip = {1'b0, b0[3:0]}; bunch = b1; fresh = 1;
				end
				K_TRAILER: begin
					if (!started) flag_error(ST_TRL_NO_HDR);
					else if (finished) flag_error(ST_TRL_FINISHED);
					else begin
						flags = b0[3:0]; finished = 1; chip = CHIP_NONE;
					end
				end
				K_REGION: begin
					if (!started) flag_error(ST_REGION_EARLY);
					else region = {1'b0, b0[4:0]};
				end
				K_SHORT: data_hits(b0, b1, 8'd0, 1'b0);
				K_LONG: data_hits(b0, b1, b2, 1'b1);
				K_UNKNOWN: flag_error(ST_UNKNOWN);
				default: ;
			endcase
		endfunction

		function void note_byte(logic [7:0] b, bit eoe);
			int n_prior;
			logic [3:0] st;
			n_prior = pending.size();
			if (err == ST_OK) begin
				if (wpos == 0) begin
					wkind = classify(b);
					word0 = b;
					if (word_length(wkind) == 2'd1) decode(b, 8'd0, 8'd0);
					else wpos = 1;
				end else if (wpos == 1) begin
					word1 = b;
					if (word_length(wkind) == 2'd2) begin
						wpos = 0;
						decode(word0, b, 8'd0);
					end else wpos = 2;
				end else begin
					wpos = 0;
					decode(word0, word1, b);
				end
				if (err != ST_OK) wpos = 0;
			end
			if (eoe) begin
				if (err == ST_OK && wpos != 0) flag_error(ST_TRUNCATED);
				if (err != ST_OK) st = err;
				else if (started && finished) st = ST_OK;
				else if (started) st = ST_UNFINISHED;
				else st = ST_NOT_STARTED;
				push(1'b1, 5'd0, 4'd0, 11'd0, st, WARN_NONE, skip);
				clear_event();
			end
			if (pending.size() > n_prior) pending[$].last = 1;
		endfunction

		task report(string what, readout_result_t got, readout_result_t want);
			errors++;
			$display("mismatch %s: got %h want %h", what, got, want);
		endtask

		task check(readout_result_t got);
			readout_result_t want;
			if (pending.size() == 0) begin
				report("unexpected word", got, got);
				return;
			end
			want = pending.pop_front();
			if (got.kind) status_seen++; else hits_seen++;
			if (got.kind != want.kind) report("result_kind", got, want);
			if (got.chip != want.chip) report("hit_chip", got, want);
			if (got.region != want.region) report("region_index", got, want);
			if (got.dcol != want.dcol) report("col_pair", got, want);
			if (got.addr != want.addr) report("pixel_address", got, want);
			if (got.bunch != want.bunch) report("hit_bunch", got, want);
			if (got.flags != want.flags) report("trailer_bits", got, want);
			if (got.status != want.status) report("status", got, want);
			if (got.warn != want.warn) report("warn_code", got, want);
			if (got.skip != want.skip) report("skipped_words", got, want);
			if (got.last != want.last) report("last_of_run", got, want);
		endtask
	endclass

	logic clk, arst_n;
	logic s_tvalid, s_tready, s_tlast;
	logic [7:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser, m_tlast;
	logic [55:0] m_tdata;

	pixel_readout_stream_decoder dut (.*);

	readout_scoreboard sb = new();
	int send_idle_pct = 28, recv_idle_pct = 70;
	bit hold_off = 0;
	int quiet_cycles = 0;
	int bytes_sent = 0;
	logic [7:0] byte_q[$];
	bit eoe_q[$];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				readout_result_t r;
				r.kind = m_tuser; r.chip = m_tdata[4:0]; r.region = m_tdata[9:5];
				r.dcol = m_tdata[13:10]; r.addr = m_tdata[24:14]; r.bunch = m_tdata[32:25];
				r.flags = m_tdata[36:33]; r.status = m_tdata[40:37]; r.warn = m_tdata[42:41];
				r.skip = m_tdata[50:43]; r.last = m_tlast;
				sb.check(r);
			end
			m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		s_tvalid = 0;
		s_tdata = 0;
		s_tlast = 0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("watchdog expired, %0d results outstanding", sb.pending.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	task send_byte(logic [7:0] b, bit eoe);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= b;
		s_tlast <= eoe;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_byte(b, eoe);
		bytes_sent++;
	endtask

	// drop valid after the last word of a burst
	task end_burst();
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task q(logic [7:0] b, bit eoe = 0);
		byte_q = {byte_q, b};
		eoe_q = {eoe_q, eoe};
	endtask

	task flush_queue();
		while (byte_q.size() > 0) send_byte(byte_q.pop_front(), eoe_q.pop_front());
	endtask

	task wait_drained();
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// one mostly well-formed event with random content
	task build_event();
		int nchip;
		nchip = $urandom_range(1, 2);
		for (int c = 0; c < nchip; c++) begin
			if ($urandom_range(9) == 0) begin
				q(8'he0 | 8'($urandom_range(15)));
				q(8'($urandom));
				continue;
			end
			q(8'ha0 | 8'($urandom_range(15)));
			q(8'($urandom));
			for (int w = 0; w < $urandom_range(1, 5); w++) begin
				case ($urandom_range(9))
					0, 1: q(8'hc0 | 8'($urandom_range(31)));
					2, 3, 4: begin
						q(8'h40 | 8'($urandom_range(63)));
						q(8'($urandom));
					end
					5, 6, 7: begin
						q(8'($urandom_range(63)));
						q(8'($urandom));
						q(8'($urandom) & 8'h7f);
					end
					8: q($urandom_range(1) ? 8'hff : ($urandom_range(1) ? 8'hf1 : 8'hf0));
					default: q(8'($urandom));
				endcase
			end
			if ($urandom_range(7) != 0) q(8'hb0 | 8'($urandom_range(15)));
		end
		if ($urandom_range(9) == 0) q(8'($urandom));
		eoe_q[$] = 1;
	endtask

	task random_phase(int nbytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < nbytes) begin
			build_event();
			flush_queue();
		end
		end_burst();
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		// directed events
		q(8'ha3); q(8'h12); q(8'hc0); q(8'h40); q(8'h05);
		q(8'h3f); q(8'hff); q(8'h7f); q(8'h3f); q(8'hff); q(8'h7f);
		q(8'h00); q(8'h00); q(8'h00); q(8'hbf, 1);
		q(8'hef); q(8'hff, 1);
		q(8'h40); q(8'h00); q(8'hb1, 1);
		q(8'ha0); q(8'h00); q(8'h41); q(8'h00); q(8'hc5); q(8'hf1); q(8'hf0);
		q(8'h80); q(8'h12, 1);
		q(8'hc2, 1);
		q(8'ha1, 1);
		q(8'hb0, 1);
		q(8'he1); q(8'h00); q(8'hb0, 1);
		q(8'ha1); q(8'h55); q(8'hc1); q(8'h1f, 1);
		flush_queue();
		end_burst();
		wait_drained();
		random_phase(80);
		send_idle_pct = 70; recv_idle_pct = 28;
		random_phase(80);
		send_idle_pct = 0; recv_idle_pct = 0;
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			random_phase(35);
		join
		wait_drained();
		random_phase(50);
		wait_drained();
		repeat (50) @(posedge clk);
		$display("%0d bytes sent, %0d hits and %0d event statuses checked",
			bytes_sent, sb.hits_seen, sb.status_seen);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/prsd_pkg.sv
rtl/core/prsd_front.sv
rtl/core/prsd_queue.sv
rtl/core/prsd_back.sv
rtl/core/pixel_readout_stream_decoder.sv
rtl/core/prsd_checker.sv
test/pixel_readout_stream_decoder_test.sv
